### src/tgl_pkg.sv
package tgl_pkg;

	localparam int MAX_CHARS_DEF = 256;
	localparam int ATLAS_COLS    = 12;
	localparam int TILE_ROWS     = 8;

	localparam logic [7:0] CODE_NL         = 8'd10;
	localparam logic [7:0] CODE_BLANK      = 8'd32;
	localparam logic [7:0] CODE_UPPER_LAST = 8'd90;
	localparam logic [7:0] CODE_PRINT_LAST = 8'd126;
	localparam logic [7:0] CODE_LOWER_A    = 8'd97;
	localparam logic [7:0] CODE_LOWER_Z    = 8'd122;
	localparam logic [7:0] CASE_FOLD       = 8'd32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [7:0] ADVANCE_X_RST = 8'd6;
	localparam logic [7:0] ADVANCE_Y_RST = 8'd6;
	localparam logic [7:0] GLYPH_W_RST   = 8'd5;
	localparam logic [7:0] GLYPH_H_RST   = 8'd5;
	localparam logic [8:0] CAPACITY_RST  = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FONT_MODE = 3'd0,
		REG_ADVANCE_X = 3'd1,
		REG_ADVANCE_Y = 3'd2,
		REG_GLYPH_W   = 3'd3,
		REG_GLYPH_H   = 3'd4,
		REG_CAPACITY  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		FONT_UPPER = 1'b0,
		FONT_PRINT = 1'b1
	} font_mode_t;

	typedef struct packed {
		logic       font_mode;
		logic [7:0] advance_x;
		logic [7:0] advance_y;
		logic [7:0] glyph_w;
		logic [7:0] glyph_h;
		logic [8:0] capacity;
	} tgl_cfg_t;

	// What stage 2 needs to know about an item besides the multiplier operands.
	typedef struct packed {
		logic       is_size;
		logic       visible;
		logic       has_size;
		logic [3:0] tile_col;
		logic [2:0] tile_row;
	} tgl_item_t;

	function automatic logic [6:0] glyph_index(input logic [7:0] code, input logic mode);
		logic [7:0] c;
		logic [7:0] last;
		c = code;
		if (c == CODE_NL) begin
			c = CODE_BLANK;
		end
		if (mode == FONT_UPPER) begin
			if (c >= CODE_LOWER_A && c <= CODE_LOWER_Z) begin
				c = c - CASE_FOLD;
			end
			last = CODE_UPPER_LAST;
		end else begin
			last = CODE_PRINT_LAST;
		end
		if (c < CODE_BLANK || c > last) begin
			c = CODE_BLANK;
		end
		return 7'(c - CODE_BLANK);
	endfunction

	// Divide by the atlas width with a row of threshold compares.
	function automatic logic [2:0] tile_row_of(input logic [6:0] idx);
		logic [2:0] r;
		r = '0;
		for (int k = 1; k < TILE_ROWS; k++) begin
			if (idx >= 7'(k * ATLAS_COLS)) begin
				r = r + 3'd1;
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] tile_col_of(input logic [6:0] idx);
		logic [2:0] r;
		logic [6:0] base;
		r = tile_row_of(idx);
		base = 7'(r) * 7'(ATLAS_COLS);
		return 4'(idx - base);
	endfunction

endpackage

### src/tgl_cfg_regs.sv
module tgl_cfg_regs
	import tgl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output tgl_cfg_t              cfg
);

	tgl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_mode <= FONT_UPPER;
			cfg_q.advance_x <= ADVANCE_X_RST;
			cfg_q.advance_y <= ADVANCE_Y_RST;
			cfg_q.glyph_w   <= GLYPH_W_RST;
			cfg_q.glyph_h   <= GLYPH_H_RST;
			cfg_q.capacity  <= CAPACITY_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_FONT_MODE: cfg_q.font_mode <= cfg_data[0];
				REG_ADVANCE_X: cfg_q.advance_x <= cfg_data[7:0];
				REG_ADVANCE_Y: cfg_q.advance_y <= cfg_data[7:0];
				REG_GLYPH_W:   cfg_q.glyph_w   <= cfg_data[7:0];
				REG_GLYPH_H:   cfg_q.glyph_h   <= cfg_data[7:0];
				REG_CAPACITY:  cfg_q.capacity  <= cfg_data[8:0];
				default: begin
					// unknown index: ignore
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/tgl_track.sv
module tgl_track
	import tgl_pkg::*;
#(
	parameter int MAX_CHARS = MAX_CHARS_DEF,
	parameter int CNT_W     = $clog2(MAX_CHARS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tgl_cfg_t         cfg,
	input  logic             in_fire,
	input  logic             req_type,
	input  logic [7:0]       char_code,
	output tgl_item_t        item_s1,
	output logic [CNT_W-1:0] mul_a_s1,
	output logic [CNT_W-1:0] mul_b_s1
);

	localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;

	logic [CNT_W-1:0] cur_col_q, cur_row_q, widest_q, count_q;
	logic [CNT_W-1:0] next_col;
	logic [LIM_W-1:0] cap_ext, max_ext, limit, count_ext;
	logic             full;
	logic             is_nl;
	logic [6:0]       idx;
	tgl_item_t        item_d;

	assign cap_ext   = LIM_W'(cfg.capacity);
	assign max_ext   = LIM_W'(MAX_CHARS);
	assign limit     = (cap_ext < max_ext) ? cap_ext : max_ext;
	assign count_ext = LIM_W'(count_q);
	assign full      = (count_ext >= limit);
	assign is_nl     = (char_code == CODE_NL);
	assign next_col  = is_nl ? '0 : cur_col_q + CNT_W'(1);
	assign idx       = glyph_index(char_code, cfg.font_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			widest_q  <= '0;
			count_q   <= '0;
		end else if (in_fire) begin
			if (req_type) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
				widest_q  <= '0;
				count_q   <= '0;
			end else if (!full) begin
				cur_col_q <= next_col;
				if (is_nl) begin
					cur_row_q <= cur_row_q + CNT_W'(1);
				end
				if (next_col > widest_q) begin
					widest_q <= next_col;
				end
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		item_d.is_size  = req_type;
		item_d.visible  = !req_type && !full;
		item_d.has_size = req_type && (widest_q != '0);
		item_d.tile_col = tile_col_of(idx);
		item_d.tile_row = tile_row_of(idx);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1  <= item_d;
			mul_a_s1 <= req_type ? widest_q - CNT_W'(1) : cur_col_q;
			mul_b_s1 <= cur_row_q;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_type |=> cur_col_q == '0 && cur_row_q == '0 && widest_q == '0
			&& count_q == '0)
		else $error("counters not cleared after end of string");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CHARS))
		else $error("character count above its limit");

	a_col_in_widest: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= widest_q)
		else $error("current column beyond widest column");

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !req_type && full |=> $stable(count_q) && $stable(cur_col_q)
			&& $stable(cur_row_q))
		else $error("dropped character changed the counters");

endmodule

### src/tgl_place.sv
module tgl_place
	import tgl_pkg::*;
#(
	parameter int CNT_W = $clog2(MAX_CHARS_DEF + 1)
) (
	input  logic             clk,
	input  logic             load,
	input  tgl_cfg_t         cfg,
	input  tgl_item_t        item_s1,
	input  logic [CNT_W-1:0] mul_a_s1,
	input  logic [CNT_W-1:0] mul_b_s1,
	output logic             is_size_s2,
	output logic             visible_s2,
	output logic [3:0]       tile_col_s2,
	output logic [2:0]       tile_row_s2,
	output logic [15:0]      pos_x_s2,
	output logic [15:0]      pos_y_s2,
	output logic [15:0]      text_w_s2,
	output logic [15:0]      text_h_s2
);

	localparam int PROD_W = CNT_W + 8;
	localparam int SUM_W  = (CNT_W + 9 > 17) ? CNT_W + 9 : 17;

	logic [PROD_W-1:0] prod_x, prod_y;
	logic [SUM_W-1:0]  sum_x, sum_y;
	logic [15:0]       val_x, val_y;

	assign prod_x = PROD_W'(mul_a_s1) * PROD_W'(cfg.advance_x);
	assign prod_y = PROD_W'(mul_b_s1) * PROD_W'(cfg.advance_y);
	assign sum_x  = SUM_W'(prod_x) + (item_s1.is_size ? SUM_W'(cfg.glyph_w) : '0);
	assign sum_y  = SUM_W'(prod_y) + (item_s1.is_size ? SUM_W'(cfg.glyph_h) : '0);
	assign val_x  = (sum_x > SUM_W'(16'hFFFF)) ? 16'hFFFF : sum_x[15:0];
	assign val_y  = (sum_y > SUM_W'(16'hFFFF)) ? 16'hFFFF : sum_y[15:0];

	always_ff @(posedge clk) begin
		if (load) begin
			is_size_s2  <= item_s1.is_size;
			visible_s2  <= item_s1.visible;
			tile_col_s2 <= item_s1.visible ? item_s1.tile_col : '0;
			tile_row_s2 <= item_s1.visible ? item_s1.tile_row : '0;
			pos_x_s2    <= item_s1.visible ? val_x : '0;
			pos_y_s2    <= item_s1.visible ? val_y : '0;
			text_w_s2   <= item_s1.has_size ? val_x : '0;
			text_h_s2   <= item_s1.has_size ? val_y : '0;
		end
	end

endmodule

### src/text_glyph_layout_core.sv
// Text layout for a tiled bitmap font. Feed a string one character per request
// (s_tuser 0, byte in s_tdata) and close it with an end request (s_tuser 1).
// Each character returns one placement: the tile in a 12-column atlas and the
// pen position column*advance_x, row*advance_y. A newline places a blank tile
// and moves the pen to the start of the next line; codes outside the selected
// font become blank, and in the uppercase font lowercase folds to uppercase.
// Once min(capacity, MAX_CHARS) characters are placed, further ones come back
// with visible 0 and all other fields 0. The end request returns the bounding
// size (m_tuser 1), zero for an empty string, and clears the counters. All
// pixel values saturate at 65535. Throughput is one request per cycle unless
// m_tready holds the result: the column, row and count registers take a single
// add and compare per request, and the position multipliers sit one register
// later. Write configuration only while no request is in flight.
module text_glyph_layout_core
	import tgl_pkg::*;
#(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] char_code
	input  logic                  s_tuser,   // [0] req_type
	// result side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [71:0]           m_tdata,   // [0] visible, [4:1] tile_col, [7:5] tile_row,
	                                         // [23:8] pos_x, [39:24] pos_y,
	                                         // [55:40] text_w, [71:56] text_h
	output logic                  m_tuser    // [0] is_size
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);

	tgl_cfg_t         cfg;
	tgl_item_t        item_s1;
	logic [CNT_W-1:0] mul_a_s1, mul_b_s1;
	logic             s1_valid_q, out_valid_q;
	logic             advance, in_fire;
	logic             is_size_s2, visible_s2;
	logic [3:0]       tile_col_s2;
	logic [2:0]       tile_row_s2;
	logic [15:0]      pos_x_s2, pos_y_s2, text_w_s2, text_h_s2;

	// The result register moves whenever it is empty or being taken; stage 1
	// accepts a new request when it is empty or is moving into the result register.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || advance;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	tgl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: update the pen counters and look up the tile.
	tgl_track #(
		.MAX_CHARS (MAX_CHARS),
		.CNT_W     (CNT_W)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_fire   (in_fire),
		.req_type  (s_tuser),
		.char_code (s_tdata),
		.item_s1   (item_s1),
		.mul_a_s1  (mul_a_s1),
		.mul_b_s1  (mul_b_s1)
	);

	// Stage 2: scale to pixels, saturate and hold the result.
	tgl_place #(
		.CNT_W (CNT_W)
	) u_place (
		.clk         (clk),
		.load        (advance && s1_valid_q),
		.cfg         (cfg),
		.item_s1     (item_s1),
		.mul_a_s1    (mul_a_s1),
		.mul_b_s1    (mul_b_s1),
		.is_size_s2  (is_size_s2),
		.visible_s2  (visible_s2),
		.tile_col_s2 (tile_col_s2),
		.tile_row_s2 (tile_row_s2),
		.pos_x_s2    (pos_x_s2),
		.pos_y_s2    (pos_y_s2),
		.text_w_s2   (text_w_s2),
		.text_h_s2   (text_h_s2)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = is_size_s2;
	assign m_tdata  = {text_h_s2, text_w_s2, pos_y_s2, pos_x_s2,
	                   tile_row_s2, tile_col_s2, visible_s2};

endmodule
